// ===== hdl/wavetable_morph_quintic_interp_macros.svh =====
// Assertion macros for the checker file.
`ifndef WAVETABLE_MORPH_QUINTIC_INTERP_MACROS_SVH
`define WAVETABLE_MORPH_QUINTIC_INTERP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define WMQI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define WMQI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wmqi_pkg.sv =====
package wmqi_pkg;

  localparam int SAMPLES_PER_HALF_DEF = 256;
  localparam int NUM_TABLES_DEF       = 9;

  localparam int IN_W     = 72;
  localparam int OUT_W    = 16;
  localparam int CFG_W    = 5;
  localparam int NUM_TAPS = 6;
  localparam int NUM_RD   = 2 * NUM_TAPS;
  localparam int QDEPTH   = 4;

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    REG_SHIFT_RIGHT = 1'b0,
    REG_SHIFT_LEFT  = 1'b1
  } reg_e;

  // classified request, front to back
  typedef struct packed {
    op_e         op;
    logic        wr_ok;
    logic [15:0] wdata;
    logic [15:0] w;
    logic [15:0] frac;
  } wmqi_ctl_t;

endpackage

// ===== hdl/wmqi_front.sv =====
module wmqi_front #(
  parameter int SamplesPerHalf = 256,
  parameter int NumTables      = 9,
  parameter int AW             = 13
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [0:0]                             cfg_index_i,
  input  logic [wmqi_pkg::CFG_W-1:0]             cfg_wdata_i,
  input  logic                                   tuser_i,
  input  logic [wmqi_pkg::IN_W-1:0]              tdata_i,
  output wmqi_pkg::wmqi_ctl_t                    ctl_o,
  output logic [wmqi_pkg::NUM_RD-1:0][AW-1:0]    addr_o
);
  import wmqi_pkg::*;

  localparam int RowLen = 2 * SamplesPerHalf + 5;
  localparam int RW     = $clog2(NumTables);
  localparam int PW     = $clog2(RowLen);

  logic [3:0]  shr_q;
  logic [4:0]  shl_q;
  logic [3:0]  ti;
  logic [9:0]  si;
  logic [24:0] phase;
  logic [11:0] morph;
  logic [11:0] fam;
  logic [12:0] fam1;
  logic [31:0] rem32, frac32, waddr32;
  logic [RW-1:0] lrow, rrow;
  logic [NUM_TAPS-1:0][PW-1:0] posc;
  logic [NUM_RD-1:0][31:0] raddr32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shr_q <= 4'd9;
      shl_q <= 5'd7;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_SHIFT_RIGHT: shr_q <= cfg_wdata_i[3:0];
        REG_SHIFT_LEFT:  shl_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign ti    = tdata_i[3:0];
  assign si    = tdata_i[13:4];
  assign phase = tdata_i[54:30];
  assign morph = tdata_i[66:55];

  assign fam    = morph >> shr_q;
  assign fam1   = {1'b0, fam} + 13'd1;
  assign rem32  = {20'd0, morph} & ~(32'hFFFF_FFFF << shr_q);
  assign frac32 = rem32 << shl_q;
  assign lrow   = (32'(fam) >= 32'(NumTables - 1)) ? RW'(NumTables - 1) : fam[RW-1:0];
  assign rrow   = (32'(fam1) >= 32'(NumTables - 1)) ? RW'(NumTables - 1) : fam1[RW-1:0];

  always_comb begin
    logic [31:0] pos32;
    for (int j = 0; j < NUM_TAPS; j++) begin
      pos32 = 32'(phase[24:16]) + 32'(j);
      if (pos32 > 32'(RowLen - 1)) pos32 = 32'(RowLen - 1);
      posc[j] = pos32[PW-1:0];
      raddr32[j]            = 32'(lrow) * 32'(RowLen) + 32'(posc[j]);
      raddr32[j + NUM_TAPS] = 32'(rrow) * 32'(RowLen) + 32'(posc[j]);
    end
  end

  assign waddr32 = 32'(ti) * 32'(RowLen) + 32'(si);

  always_comb begin
    for (int k = 0; k < NUM_RD; k++) addr_o[k] = raddr32[k][AW-1:0];
    if (op_e'(tuser_i) == OP_WRITE) addr_o[0] = waddr32[AW-1:0];
  end

  assign ctl_o.op    = op_e'(tuser_i);
  assign ctl_o.wr_ok = (32'(ti) < 32'(NumTables)) && (32'(si) < 32'(RowLen));
  assign ctl_o.wdata = tdata_i[29:14];
  assign ctl_o.w     = phase[15:0];
  assign ctl_o.frac  = frac32[15:0];

endmodule

// ===== hdl/wmqi_queue.sv =====
module wmqi_queue #(
  parameter int W     = 8,
  parameter int Depth = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         ready_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);
  import wmqi_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [W-1:0]    mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign ready_o = cnt_q != CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign push    = push_i && ready_o;
  assign pop     = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + PtrW'(1);
      if (pop) rd_q <= rd_q + PtrW'(1);
      if (push && !pop) cnt_q <= cnt_q + CntW'(1);
      else if (pop && !push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

// ===== hdl/wmqi_back.sv =====
module wmqi_back #(
  parameter int SamplesPerHalf = 256,
  parameter int NumTables      = 9,
  parameter int AW             = 13
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  wmqi_pkg::wmqi_ctl_t                 ctl_i,
  input  logic [wmqi_pkg::NUM_RD-1:0][AW-1:0] addr_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [11:0]                         sample_o,
  output logic                                gate_o
);
  import wmqi_pkg::*;

  localparam int Depth = NumTables * (2 * SamplesPerHalf + 5);
  localparam logic [19:0] Recip24 = 20'd699051;

  typedef struct packed {
    logic               v;
    logic               up;
    logic               dn;
    logic [15:0]        w;
    logic [31:0]        pc;
    logic [3:0][31:0]   c;
    logic signed [48:0] m;
  } hs_t;

  function automatic logic [15:0] blend(logic [15:0] a, logic [15:0] b, logic [15:0] f);
    logic [32:0] t;
    t = 33'(a) * (33'd65536 - 33'(f)) + 33'(b) * 33'(f);
    return t[31:16];
  endfunction

  logic en, wr_en, rd_en;
  logic [NUM_RD-1:0][15:0] rd_q;
  logic        v0_q, v1_q;
  logic [15:0] w0_q, frac0_q, w1_q;
  logic [NUM_TAPS-1:0][15:0] p_q;
  hs_t         s2_d, s2_q;
  logic [31:0] c5_q;
  hs_t         hs_d [0:4];
  hs_t         hs_q [0:4];
  logic [31:0] t_d [0:4];
  logic signed [48:0] mul_d [0:4];
  logic        v8_q, up8_q, dn8_q;
  logic [31:0] pc8_q, r;
  logic signed [55:0] q_d, q8_q;
  logic [11:0] sat;
  logic        out_valid_q, gate_q;
  logic [11:0] sample_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign wr_en      = en && in_valid_i && ctl_i.op == OP_WRITE && ctl_i.wr_ok;
  assign rd_en      = en && in_valid_i && ctl_i.op == OP_LOOKUP;

  for (genvar k = 0; k < NUM_RD; k++) begin : g_bank
    logic [15:0] mem [Depth];
    always_ff @(posedge clk_i) begin
      if (wr_en) mem[addr_i[0]] <= ctl_i.wdata;
      if (rd_en) rd_q[k] <= mem[addr_i[k]];
    end
  end

  // spline coefficients, 32-bit wrap
  always_comb begin
    logic [31:0] q0, q1, q2, q3, q4, q5;
    q0 = 32'(p_q[0]); q1 = 32'(p_q[1]); q2 = 32'(p_q[2]);
    q3 = 32'(p_q[3]); q4 = 32'(p_q[4]); q5 = 32'(p_q[5]);
    s2_d.v    = v1_q;
    s2_d.up   = p_q[2] < p_q[3];
    s2_d.dn   = p_q[3] < p_q[2];
    s2_d.w    = w1_q;
    s2_d.pc   = q2;
    s2_d.c[3] = q2 * 32'd126 - q3 * 32'd124 + q4 * 32'd61 - q1 * 32'd64
              - q5 * 32'd12 + q0 * 32'd13;
    s2_d.c[2] = q3 * 32'd66 - q2 * 32'd70 - q4 * 32'd33 + q1 * 32'd39
              + q5 * 32'd7 - q0 * 32'd9;
    s2_d.c[1] = (q3 + q1) * 32'd16 - q0 - q2 * 32'd30 - q4;
    s2_d.c[0] = (q3 - q1) * 32'd16 + (q0 - q4) * 32'd2;
    s2_d.m    = '0;
  end

  always_comb begin
    t_d[0]    = c5_q;
    mul_d[0]  = $signed({1'b0, s2_q.w}) * $signed(t_d[0]);
    hs_d[0]   = s2_q;
    hs_d[0].m = mul_d[0];
    for (int k = 1; k < 5; k++) begin
      t_d[k]    = hs_q[k-1].c[4-k] + hs_q[k-1].m[47:16];
      mul_d[k]  = $signed({1'b0, hs_q[k-1].w}) * $signed(t_d[k]);
      hs_d[k]   = hs_q[k-1];
      hs_d[k].m = mul_d[k];
    end
  end

  assign q_d = $signed({1'b0, Recip24}) * $signed(hs_q[4].m[47:16]);
  assign r   = pc8_q + q8_q[55:24];

  always_comb begin
    if (r[31]) sat = 12'd0;
    else if (|r[30:15]) sat = 12'd4095;
    else sat = r[14:3];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w0_q    <= ctl_i.w;
      frac0_q <= ctl_i.frac;
      w1_q    <= w0_q;
      for (int j = 0; j < NUM_TAPS; j++) p_q[j] <= blend(rd_q[j], rd_q[j+NUM_TAPS], frac0_q);
      s2_q    <= s2_d;
      c5_q    <= (32'(p_q[3]) - 32'(p_q[2])) * 32'd50
               + (32'(p_q[1]) - 32'(p_q[4])) * 32'd25
               + (32'(p_q[5]) - 32'(p_q[0])) * 32'd5;
      for (int k = 0; k < 5; k++) hs_q[k] <= hs_d[k];
      pc8_q    <= hs_q[4].pc;
      up8_q    <= hs_q[4].up;
      dn8_q    <= hs_q[4].dn;
      q8_q     <= q_d;
      sample_q <= sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v8_q        <= 1'b0;
      out_valid_q <= 1'b0;
      gate_q      <= 1'b0;
    end else if (en) begin
      v0_q        <= rd_en;
      v1_q        <= v0_q;
      v8_q        <= hs_q[4].v;
      out_valid_q <= v8_q;
      if (v8_q && up8_q) gate_q <= 1'b1;
      else if (v8_q && dn8_q) gate_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign gate_o      = gate_q;

endmodule

// ===== hdl/wavetable_morph_quintic_interp.sv =====
// Wavetable morph with quintic spline interpolation. Takes one request per clock
// while the queue has room and returns one sample per lookup, in order; table writes
// return nothing. The rate is set by twelve copies of the table memory, each written
// by every table write and each read at one of the twelve tap addresses per lookup,
// so all taps are read together. A four-entry queue sits between the classifying
// front and the memory and spline pipeline, so up to four more requests are taken
// while the output is held. Table contents are undefined until written; there is no
// clearing pass after reset.
module wavetable_morph_quintic_interp #(
  parameter int SamplesPerHalf = wmqi_pkg::SAMPLES_PER_HALF_DEF,
  parameter int NumTables      = wmqi_pkg::NUM_TABLES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_index_i,
  input  logic [wmqi_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // table_index, sample_index, sample_value, phase, morph
  input  logic [wmqi_pkg::IN_W-1:0]      s_axis_tdata_i,
  // operation
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // sample_out, direction_gate
  output logic [wmqi_pkg::OUT_W-1:0]     m_axis_tdata_o
);
  import wmqi_pkg::*;

  localparam int AW = $clog2(NumTables * (2 * SamplesPerHalf + 5));
  localparam int QW = $bits(wmqi_ctl_t) + NUM_RD * AW;

  wmqi_ctl_t                   f_ctl, b_ctl;
  logic [NUM_RD-1:0][AW-1:0]   f_addr, b_addr;
  logic                        q_valid, b_ready;
  logic [11:0]                 sample;
  logic                        gate;

  wmqi_front #(
    .SamplesPerHalf(SamplesPerHalf),
    .NumTables     (NumTables),
    .AW            (AW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .tuser_i    (s_axis_tuser_i),
    .tdata_i    (s_axis_tdata_i),
    .ctl_o      (f_ctl),
    .addr_o     (f_addr)
  );

  wmqi_queue #(
    .W    (QW),
    .Depth(QDEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s_axis_tvalid_i),
    .data_i ({f_ctl, f_addr}),
    .ready_o(s_axis_tready_o),
    .pop_i  (b_ready),
    .valid_o(q_valid),
    .data_o ({b_ctl, b_addr})
  );

  wmqi_back #(
    .SamplesPerHalf(SamplesPerHalf),
    .NumTables     (NumTables),
    .AW            (AW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_valid),
    .in_ready_o (b_ready),
    .ctl_i      (b_ctl),
    .addr_i     (b_addr),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .sample_o   (sample),
    .gate_o     (gate)
  );

  assign m_axis_tdata_o = {3'b000, gate, sample};

endmodule

// ===== hdl/wmqi_checker.sv =====
`include "wavetable_morph_quintic_interp_macros.svh"

module wmqi_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_o,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [wmqi_pkg::OUT_W-1:0] m_axis_tdata_o
);

  `WMQI_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")
  `WMQI_ASSERT_SAME(a_pad_zero, m_axis_tvalid_o, m_axis_tdata_o[15:13] == 3'b000, "output padding not zero")
  `WMQI_ASSERT_SAME(a_full_cause, $fell(s_axis_tready_o), $past(s_axis_tvalid_i && s_axis_tready_o), "queue filled without a request")

endmodule

bind wavetable_morph_quintic_interp wmqi_checker u_wmqi_checker (.*);
